FILE: sv/segment_allocator_first_best_fit_defines.svh
// Assertion macros for the segment allocator.
`ifndef SEGMENT_ALLOCATOR_FIRST_BEST_FIT_DEFINES_SVH
`define SEGMENT_ALLOCATOR_FIRST_BEST_FIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SA_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SA_ASSERT(label, clk, rst_n, prop, msg)
`define SA_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

FILE: sv/sa_pkg.sv
// Package with sizes, status codes and opcodes of the segment allocator.
`default_nettype none
package sa_pkg;
	localparam int unsigned POOL_SIZE  = 1048576;
	localparam int unsigned FREE_SLOTS = 64;
	localparam int unsigned USED_SLOTS = 64;
	localparam int unsigned OFF_W  = 21;
	localparam int unsigned FIDX_W = $clog2(FREE_SLOTS);
	localparam int unsigned FCNT_W = $clog2(FREE_SLOTS + 1);
	localparam int unsigned UIDX_W = $clog2(USED_SLOTS);
	localparam int unsigned UCNT_W = $clog2(USED_SLOTS + 1);
	localparam int unsigned CNT_W  = 12;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ZERO    = 3'd1;
	localparam logic [2:0] ST_NOFIT   = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic ADDR_FIT_MODE  = 1'b0;
	localparam logic ADDR_POOL_BASE = 1'b1;

	typedef logic [OFF_W-1:0] off_t;
endpackage
`default_nettype wire

FILE: sv/sa_if.sv
// Valid/ready channel interfaces for request and result words.
`default_nettype none
interface sa_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [20:0] req_size;
	logic [31:0] release_addr;
	modport source (output valid, opcode, req_size, release_addr, input ready);
	modport sink (input valid, opcode, req_size, release_addr, output ready);
endinterface

interface sa_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] seg_addr;
	logic [7:0]  probes;
	modport source (output valid, status, seg_addr, probes, input ready);
	modport sink (input valid, status, seg_addr, probes, output ready);
endinterface
`default_nettype wire

FILE: sv/segment_allocator_first_best_fit.sv
// Top level of the segment allocator with its sequencer and tables.
//
// A request word on req carries an opcode, a size and a release address.
// Exactly one result word per request leaves on rsp with status, address
// and the count of free-table entries visited. The APB port writes fit_mode
// (address 0) and pool_base (address 4) and reads them back.
// One request is worked on at a time and req is not ready until the result
// word of the previous request has been taken. Scans go through a single
// compare unit: the free-table search reads and then compares each entry,
// the used-slot search tests one slot at a time and on free also reads each
// occupied slot, and a table shift moves one entry at a time. req is ready
// again in the cycle after the result word leaves.
// After reset the free table holds one segment covering the whole pool,
// no segment is allocated, and both registers are zero; req stays low in the
// first cycle while the table is set up. A stalled rsp holds its word in the
// output register and the block waits with it.
`default_nettype none
module segment_allocator_first_best_fit import sa_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	sa_req_if.sink      req,
	sa_rsp_if.source    rsp,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
`include "segment_allocator_first_best_fit_defines.svh"

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FSCAN = 4'd1;
	localparam logic [3:0] S_FRD   = 4'd2;
	localparam logic [3:0] S_USCAN = 4'd3;
	localparam logic [3:0] S_URD   = 4'd4;
	localparam logic [3:0] S_APPLY = 4'd5;
	localparam logic [3:0] S_SHIFT = 4'd6;
	localparam logic [3:0] S_PSCAN = 4'd7;
	localparam logic [3:0] S_PRD   = 4'd8;
	localparam logic [3:0] S_MERGE = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	// Free table in flip-flop memories read at one address per cycle.
	off_t fstart_mem [FREE_SLOTS];
	logic [OFF_W:0] flen_mem [FREE_SLOTS];
	off_t ustart_mem [USED_SLOTS];
	off_t ulen_mem [USED_SLOTS];
	logic [USED_SLOTS-1:0] uvalid_q;

	logic [3:0]        state_q;
	logic              fit_mode_q;
	logic [31:0]       pool_base_q;
	logic [FCNT_W-1:0] fcount_q;
	logic              op_q;
	logic [OFF_W:0]    size_q;
	off_t              off_q;
	logic [FCNT_W-1:0] idx_q;
	logic [UCNT_W-1:0] uidx_q;
	logic [FCNT_W-1:0] pick_q;
	logic              found_q;
	logic [OFF_W:0]    blen_q;
	off_t              pstart_q;
	logic [OFF_W:0]    plen_q;
	off_t              prv_start_q;
	logic [OFF_W:0]    prv_len_q;
	logic [CNT_W-1:0]  probes_q;
	logic [UIDX_W-1:0] uslot_q;
	logic              ufound_q;
	off_t              ulen_q;
	logic              fresh_q;
	// Shift control: dir 1 moves entries up (insert), 0 moves down (drop).
	logic              sh_dir_q;
	logic [FCNT_W-1:0] sh_stop_q;
	logic [FCNT_W-1:0] sh_i_q;
	logic              sh_wr_q;
	off_t              sh_start_q;
	logic [OFF_W:0]    sh_len_q;
	logic              sh_last;

	off_t              rd_start_q;
	logic [OFF_W:0]    rd_len_q;
	off_t              urd_start_q;
	off_t              urd_len_q;

	logic              fwe;
	logic [FIDX_W-1:0] fwa;
	off_t              fwd_start;
	logic [OFF_W:0]    fwd_len;
	logic [FIDX_W-1:0] fra;
	logic              rst_fill;

	logic              req_rdy;
	logic              merge_lo;
	logic              merge_hi;

	logic [2:0]        st_q;
	logic [31:0]       addr_q;
	logic              rvalid_q;

	assign pready = 1'b1;
	assign req_rdy = (state_q == S_IDLE) && !rvalid_q && !fresh_q;
	assign req.ready = req_rdy;
	assign rsp.valid = rvalid_q;
	assign rsp.status = st_q;
	assign rsp.seg_addr = addr_q;
	assign rsp.probes = (probes_q > CNT_W'(255)) ? 8'd255 : probes_q[7:0];

	assign sh_last = sh_dir_q ? (sh_i_q <= sh_stop_q) : (sh_i_q + FCNT_W'(1) >= sh_stop_q);
	assign merge_lo = idx_q != '0 && 22'(prv_start_q) + 22'(prv_len_q) == 22'(off_q);
	assign merge_hi = idx_q < fcount_q && 22'(off_q) + 22'(ulen_q) == 22'(pstart_q);

	always_comb begin
		case (paddr[2])
			ADDR_FIT_MODE: prdata = {31'd0, fit_mode_q};
			default: prdata = pool_base_q;
		endcase
	end

	always_ff @(posedge clk) begin
		rd_start_q <= fstart_mem[fra];
		rd_len_q <= flen_mem[fra];
		urd_start_q <= ustart_mem[uidx_q[UIDX_W-1:0]];
		urd_len_q <= ulen_mem[uidx_q[UIDX_W-1:0]];
		if (fwe) begin
			fstart_mem[fwa] <= fwd_start;
			flen_mem[fwa] <= fwd_len;
		end
		if (state_q == S_APPLY && op_q == OP_ALLOC && ufound_q) begin
			ustart_mem[uslot_q] <= pstart_q;
			ulen_mem[uslot_q] <= size_q[OFF_W-1:0];
		end
	end

	// Write port of the free table and the address of its read port.
	always_comb begin
		fwe = 1'b0;
		fwa = '0;
		fwd_start = pstart_q;
		fwd_len = plen_q;
		fra = idx_q[FIDX_W-1:0];
		rst_fill = fresh_q;
		if (fresh_q) begin
			fwe = 1'b1;
			fwd_start = '0;
			fwd_len = (OFF_W+1)'(POOL_SIZE);
		end else if (state_q == S_SHIFT) begin
			if (sh_wr_q) begin
				fwe = 1'b1;
				fwa = sh_dir_q ? sh_i_q[FIDX_W-1:0] : sh_i_q[FIDX_W-1:0] - FIDX_W'(1);
				fwd_start = rd_start_q;
				fwd_len = rd_len_q;
			end
			fra = sh_dir_q ? sh_i_q[FIDX_W-1:0] - FIDX_W'(2)
			               : sh_i_q[FIDX_W-1:0] + FIDX_W'(1);
		end else if (state_q == S_APPLY || state_q == S_MERGE) begin
			fwe = (state_q == S_APPLY) ? (op_q == OP_ALLOC && ufound_q && found_q &&
				plen_q != size_q) : 1'b0;
			fwa = pick_q[FIDX_W-1:0];
			fwd_start = pstart_q + size_q[OFF_W-1:0];
			fwd_len = plen_q - size_q;
		end else if (state_q == S_DONE && sh_wr_q) begin
			fwe = 1'b1;
			fwa = pick_q[FIDX_W-1:0];
			fwd_start = sh_start_q;
			fwd_len = sh_len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fit_mode_q <= 1'b0;
			pool_base_q <= '0;
			fcount_q <= FCNT_W'(1);
			uvalid_q <= '0;
			rvalid_q <= 1'b0;
			fresh_q <= 1'b1;
			sh_wr_q <= 1'b0;
		end else begin
			if (rst_fill) fresh_q <= 1'b0;
			if (psel && penable && pwrite) begin
				if (paddr == {ADDR_FIT_MODE, 2'b00}) fit_mode_q <= pwdata[0];
				if (paddr == {ADDR_POOL_BASE, 2'b00}) pool_base_q <= pwdata;
			end
			if (rsp.valid && rsp.ready) rvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid && req_rdy) begin
						op_q <= req.opcode;
						size_q <= (OFF_W+1)'(req.req_size);
						off_q <= OFF_W'(req.release_addr - pool_base_q);
						idx_q <= '0;
						uidx_q <= '0;
						found_q <= 1'b0;
						ufound_q <= 1'b0;
						probes_q <= '0;
						addr_q <= '0;
						sh_wr_q <= 1'b0;
						if (req.opcode == OP_ALLOC) begin
							if (req.req_size == 21'd0) begin
								st_q <= ST_ZERO;
								state_q <= S_DONE;
							end else begin
								state_q <= S_FSCAN;
							end
						end else if (req.release_addr - pool_base_q >= 32'(POOL_SIZE)) begin
							st_q <= ST_UNKNOWN;
							state_q <= S_DONE;
						end else begin
							state_q <= S_USCAN;
						end
					end
				end
				// Allocate search: each free entry is read, then compared.
				S_FSCAN: begin
					if (idx_q >= fcount_q) begin
						if (found_q && fit_mode_q && blen_q == size_q)
							probes_q <= CNT_W'(fcount_q) + CNT_W'(pick_q) + CNT_W'(2);
						else
							probes_q <= CNT_W'(fcount_q) + CNT_W'(1);
						if (!found_q) begin
							st_q <= ST_NOFIT;
							state_q <= S_DONE;
						end else begin
							state_q <= S_USCAN;
						end
					end else begin
						state_q <= S_FRD;
					end
				end
				S_FRD: begin
					idx_q <= idx_q + FCNT_W'(1);
					if (rd_len_q >= size_q && (!found_q || rd_len_q < blen_q)) begin
						found_q <= 1'b1;
						pick_q <= idx_q;
						blen_q <= rd_len_q;
						pstart_q <= rd_start_q;
						plen_q <= rd_len_q;
						if (!fit_mode_q) begin
							probes_q <= CNT_W'(idx_q) + CNT_W'(1);
							state_q <= S_USCAN;
						end else begin
							state_q <= S_FSCAN;
						end
					end else begin
						state_q <= S_FSCAN;
					end
				end
				// Used-slot search: a free slot on allocate, the address on free.
				S_USCAN: begin
					if (uidx_q >= UCNT_W'(USED_SLOTS)) begin
						if (op_q == OP_ALLOC) begin
							if (!ufound_q) begin
								st_q <= ST_FULL;
								state_q <= S_DONE;
							end else begin
								state_q <= S_APPLY;
							end
						end else begin
							st_q <= ST_UNKNOWN;
							state_q <= S_DONE;
						end
					end else if (op_q == OP_ALLOC) begin
						if (!uvalid_q[uidx_q[UIDX_W-1:0]]) begin
							uslot_q <= uidx_q[UIDX_W-1:0];
							ufound_q <= 1'b1;
							state_q <= S_APPLY;
						end else begin
							uidx_q <= uidx_q + UCNT_W'(1);
						end
					end else if (uvalid_q[uidx_q[UIDX_W-1:0]]) begin
						state_q <= S_URD;
					end else begin
						uidx_q <= uidx_q + UCNT_W'(1);
					end
				end
				S_URD: begin
					if (urd_start_q == off_q) begin
						uslot_q <= uidx_q[UIDX_W-1:0];
						ulen_q <= urd_len_q;
						idx_q <= '0;
						state_q <= S_PSCAN;
					end else begin
						uidx_q <= uidx_q + UCNT_W'(1);
						state_q <= S_USCAN;
					end
				end
				S_APPLY: begin
					uvalid_q[uslot_q] <= 1'b1;
					addr_q <= pool_base_q + 32'(pstart_q);
					st_q <= ST_OK;
					if (plen_q == size_q) begin
						sh_dir_q <= 1'b0;
						sh_i_q <= pick_q;
						sh_stop_q <= fcount_q;
						fcount_q <= fcount_q - FCNT_W'(1);
						state_q <= S_SHIFT;
					end else begin
						state_q <= S_DONE;
					end
				end
				// Free: find the first entry at or above the segment.
				S_PSCAN: begin
					if (idx_q >= fcount_q) state_q <= S_MERGE;
					else state_q <= S_PRD;
				end
				S_PRD: begin
					if (rd_start_q < off_q) begin
						prv_start_q <= rd_start_q;
						prv_len_q <= rd_len_q;
						idx_q <= idx_q + FCNT_W'(1);
						state_q <= S_PSCAN;
					end else begin
						pstart_q <= rd_start_q;
						plen_q <= rd_len_q;
						state_q <= S_MERGE;
					end
				end
				S_MERGE: begin
					probes_q <= CNT_W'(idx_q) + CNT_W'(1);
					if (merge_lo && merge_hi) begin
						st_q <= ST_OK;
						uvalid_q[uslot_q] <= 1'b0;
						pick_q <= idx_q - FCNT_W'(1);
						sh_start_q <= prv_start_q;
						sh_len_q <= prv_len_q + (OFF_W+1)'(ulen_q) + plen_q;
						sh_dir_q <= 1'b0;
						sh_i_q <= idx_q;
						sh_stop_q <= fcount_q;
						fcount_q <= fcount_q - FCNT_W'(1);
						sh_wr_q <= 1'b0;
						state_q <= S_SHIFT;
					end else if (merge_lo) begin
						st_q <= ST_OK;
						uvalid_q[uslot_q] <= 1'b0;
						pick_q <= idx_q - FCNT_W'(1);
						sh_start_q <= prv_start_q;
						sh_len_q <= prv_len_q + (OFF_W+1)'(ulen_q);
						sh_wr_q <= 1'b1;
						state_q <= S_DONE;
					end else if (merge_hi) begin
						st_q <= ST_OK;
						uvalid_q[uslot_q] <= 1'b0;
						pick_q <= idx_q;
						sh_start_q <= off_q;
						sh_len_q <= plen_q + (OFF_W+1)'(ulen_q);
						sh_wr_q <= 1'b1;
						state_q <= S_DONE;
					end else if (fcount_q >= FCNT_W'(FREE_SLOTS)) begin
						st_q <= ST_FULL;
						sh_wr_q <= 1'b0;
						state_q <= S_DONE;
					end else begin
						st_q <= ST_OK;
						uvalid_q[uslot_q] <= 1'b0;
						pick_q <= idx_q;
						sh_start_q <= off_q;
						sh_len_q <= (OFF_W+1)'(ulen_q);
						sh_dir_q <= 1'b1;
						sh_i_q <= fcount_q + FCNT_W'(1);
						sh_stop_q <= idx_q + FCNT_W'(1);
						fcount_q <= fcount_q + FCNT_W'(1);
						sh_wr_q <= 1'b0;
						state_q <= S_SHIFT;
					end
				end
				// Move entries one place a step; the first step only primes a read.
				S_SHIFT: begin
					if (sh_last) begin
						sh_wr_q <= (op_q == OP_FREE);
						state_q <= S_DONE;
					end else begin
						sh_i_q <= sh_dir_q ? sh_i_q - FCNT_W'(1) : sh_i_q + FCNT_W'(1);
						sh_wr_q <= 1'b1;
					end
				end
				S_DONE: begin
					sh_wr_q <= 1'b0;
					rvalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SA_ASSERT(a_one_rsp_per_req, clk, arst_n,
		(req.valid && req.ready) |=> !req.ready, "request accepted while busy")
	`SA_ASSERT_NEVER(a_fcount_range, clk, arst_n,
		fcount_q > FCNT_W'(FREE_SLOTS), "free count exceeds table depth")
	`SA_ASSERT(a_rsp_done, clk, arst_n,
		$rose(rvalid_q) |-> $past(state_q) == S_DONE, "result without completion")
endmodule
`default_nettype wire
